// ===== src/sppq_pkg.sv =====
// ============================================================================
// sppq_pkg: shared types and constants of the sorted priority queue
// Entry layout, per-cycle cell command, status and opcode codes.
// ============================================================================
`default_nettype none

package sppq_pkg;

  localparam int QUEUE_DEPTH   = 32;
  localparam int ID_BITS       = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // Request opcodes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // One stored entry
  typedef struct packed {
    logic [ID_BITS-1:0]       id;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  // Command broadcast to every cell in a cycle
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_cmd_t;

endpackage : sppq_pkg

`default_nettype wire

// ===== src/sppq_cell.sv =====
// ============================================================================
// sppq_cell: one slot of the sorted queue chain
// Holds one entry, keeps it, takes the new entry, or shifts from a neighbor.
// ============================================================================
`default_nettype none

module sppq_cell (
  input  wire logic               clk,
  input  wire sppq_pkg::cell_cmd_t cmd,
  input  wire logic               occupied,
  input  wire logic               left_behind,
  input  wire sppq_pkg::entry_t   left_entry,
  input  wire sppq_pkg::entry_t   right_entry,
  output      sppq_pkg::entry_t   entry,
  output      logic               behind
);

  sppq_pkg::entry_t entry_next;

  // New entry goes behind this one when stored priority is equal or higher
  assign behind = occupied && (entry.prio >= cmd.new_entry.prio);

  // Select next slot content
  always_comb begin
    entry_next = entry;
    if (cmd.deq) begin
      entry_next = right_entry;
    end else if (cmd.enq && !behind) begin
      if (left_behind) begin
        entry_next = cmd.new_entry;
      end else begin
        entry_next = left_entry;
      end
    end
  end

  // Hold slot content
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule : sppq_cell

`default_nettype wire

// ===== src/stable_sorted_priority_queue_core.sv =====
// ============================================================================
// stable_sorted_priority_queue_core: stable sorted-insertion priority queue
// Chain of slot cells kept sorted by descending priority, head at slot 0.
// ============================================================================
// Usage:
//   Request channel (in_valid/in_ready): opcode, item_id, item_priority.
//   opcode OP_ENQ inserts behind every stored entry of equal or higher
//   priority; OP_DEQ removes the head. Each request yields one result on
//   the result channel (res_valid/res_ready): status, out_valid, out_id,
//   out_priority, occupancy.
//   The result is registered at the edge that accepts the request. One
//   request is taken per cycle unless a held result stalls; every cell
//   updates in parallel from the broadcast command and its neighbors.
//   An enqueue on a full queue is dropped with STATUS_FULL, a dequeue on an
//   empty queue returns STATUS_EMPTY; the queue is unchanged in both cases.
//   Reset clears the occupancy count and the result valid flag; slot contents
//   are not cleared and are only read below the count.
//   When the receiver stalls, the held result stays and in_ready drops until
//   it is taken; a request is accepted in the same cycle the result leaves.
// ============================================================================
`default_nettype none

module stable_sorted_priority_queue_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic                               opcode,
  input  wire logic [sppq_pkg::ID_BITS-1:0]       item_id,
  input  wire logic [sppq_pkg::PRIORITY_BITS-1:0] item_priority,
  output      logic                               res_valid,
  input  wire logic                               res_ready,
  output      logic [1:0]                         status,
  output      logic                               out_valid,
  output      logic [sppq_pkg::ID_BITS-1:0]       out_id,
  output      logic [sppq_pkg::PRIORITY_BITS-1:0] out_priority,
  output      logic [sppq_pkg::COUNT_BITS-1:0]    occupancy
);

  localparam logic [sppq_pkg::COUNT_BITS-1:0] FULL_COUNT =
    sppq_pkg::COUNT_BITS'(sppq_pkg::QUEUE_DEPTH);

  logic                            accept;
  logic                            is_full;
  logic                            is_empty;
  logic [sppq_pkg::COUNT_BITS-1:0] count;
  logic [sppq_pkg::COUNT_BITS-1:0] count_next;
  sppq_pkg::cell_cmd_t             cmd;
  sppq_pkg::entry_t                cell_entry [sppq_pkg::QUEUE_DEPTH];
  logic [sppq_pkg::QUEUE_DEPTH-1:0] cell_behind;

  assign in_ready = !res_valid || res_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count == FULL_COUNT);
  assign is_empty = (count == '0);

  // Build the command broadcast to all cells
  always_comb begin
    cmd.enq            = accept && (opcode == sppq_pkg::OP_ENQ) && !is_full;
    cmd.deq            = accept && (opcode == sppq_pkg::OP_DEQ) && !is_empty;
    cmd.new_entry.id   = item_id;
    cmd.new_entry.prio = item_priority;
  end

  // Advance the occupancy count
  always_comb begin
    count_next = count;
    if (cmd.enq) begin
      count_next = count + 1'b1;
    end else if (cmd.deq) begin
      count_next = count - 1'b1;
    end
  end

  // Chain of slot cells
  for (genvar i = 0; i < sppq_pkg::QUEUE_DEPTH; i++) begin : g_cell
    logic             left_behind;
    sppq_pkg::entry_t left_entry;
    sppq_pkg::entry_t right_entry;
    logic             occupied;

    assign occupied = (count > sppq_pkg::COUNT_BITS'(i));

    if (i == 0) begin : g_head
      assign left_behind = 1'b1;
      assign left_entry  = cmd.new_entry;
    end else begin : g_body
      assign left_behind = cell_behind[i-1];
      assign left_entry  = cell_entry[i-1];
    end

    if (i == sppq_pkg::QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    sppq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (occupied),
      .left_behind (left_behind),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .behind      (cell_behind[i])
    );
  end

  // Hold count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      occupancy    <= count_next;
      out_valid    <= cmd.deq;
      out_id       <= cmd.deq ? cell_entry[0].id : '0;
      out_priority <= cmd.deq ? cell_entry[0].prio : '0;
      if (opcode == sppq_pkg::OP_ENQ) begin
        status <= is_full ? sppq_pkg::STATUS_FULL : sppq_pkg::STATUS_OK;
      end else begin
        status <= is_empty ? sppq_pkg::STATUS_EMPTY : sppq_pkg::STATUS_OK;
      end
    end
  end

endmodule : stable_sorted_priority_queue_core

`default_nettype wire

// ===== src/sppq_checker.sv =====
// ============================================================================
// sppq_checker: port-level checks of the sorted priority queue
// Result handshake and result field consistency, bound to the top level.
// ============================================================================
`default_nettype none

module sppq_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               res_valid,
  input wire logic                               res_ready,
  input wire logic [1:0]                         status,
  input wire logic                               out_valid,
  input wire logic [sppq_pkg::ID_BITS-1:0]       out_id,
  input wire logic [sppq_pkg::PRIORITY_BITS-1:0] out_priority,
  input wire logic [sppq_pkg::COUNT_BITS-1:0]    occupancy
);

  // Stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(occupancy)
      && $stable(out_id))
    else $error("result changed while stalled");

  // Occupancy never exceeds depth
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> occupancy <= sppq_pkg::COUNT_BITS'(sppq_pkg::QUEUE_DEPTH))
    else $error("occupancy above depth");

  // Returned entry only with ok status, and occupancy below depth after it
  a_deq_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_valid |-> status == sppq_pkg::STATUS_OK
      && occupancy < sppq_pkg::COUNT_BITS'(sppq_pkg::QUEUE_DEPTH))
    else $error("dequeued entry with bad status or occupancy");

  // No entry fields without a returned entry
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_valid |-> out_id == '0 && out_priority == '0)
    else $error("entry fields set without dequeued entry");

  // Empty status only at zero occupancy
  a_status_occ: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == sppq_pkg::STATUS_EMPTY) |-> occupancy == '0)
    else $error("empty status with entries stored");

endmodule : sppq_checker

bind stable_sorted_priority_queue_core sppq_checker u_sppq_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res_valid),
  .res_ready    (res_ready),
  .status       (status),
  .out_valid    (out_valid),
  .out_id       (out_id),
  .out_priority (out_priority),
  .occupancy    (occupancy)
);

`default_nettype wire
